@@ rtl/rnea_pkg.sv @@
// Shared types and constants for the ring neighbor exclusion arbiter.
package rnea_pkg;

    // Fixed field widths of the channels.
    localparam int SEAT_W       = 3;
    localparam int MASK_W       = 8;
    localparam int MEALS_OUT_W  = 16;
    localparam int SEAT_COUNT_W = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 4;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_SEATS  = 8;
    localparam int DEF_MEAL_WIDTH = 16;

    // Smallest ring that the arbiter runs.
    localparam int MIN_SEATS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SEAT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 1'd1;

    // Register reset values.
    localparam logic [SEAT_COUNT_W-1:0] SEAT_COUNT_RESET = 4'd8;
    localparam logic                    ENABLE_RESET     = 1'b1;

    // Request modes.
    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [SEAT_W-1:0] seat;
    } t_req;

    typedef struct packed {
        logic [MASK_W-1:0]      grant_mask;
        logic [MASK_W-1:0]      eating_mask;
        logic [MASK_W-1:0]      hungry_mask;
        logic [MEALS_OUT_W-1:0] seat_meals;
        logic                   bad_seat;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

endpackage

@@ rtl/rnea_req_if.sv @@
// Request channel interface: valid, ready and one event.
interface rnea_req_if;
    logic          valid;
    logic          ready;
    rnea_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/rnea_rsp_if.sv @@
// Result channel interface: valid, ready and one result.
interface rnea_rsp_if;
    logic          valid;
    logic          ready;
    rnea_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/rnea_cfg_if.sv @@
// Configuration write channel interface: valid, ready, index and data.
interface rnea_cfg_if;
    logic          valid;
    logic          ready;
    rnea_pkg::t_cfg payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/rnea_cfg_regs.sv @@
// Configuration registers and the clamped ring size derived from them.
module rnea_cfg_regs #(
    parameter int MAX_SEATS = rnea_pkg::DEF_MAX_SEATS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  rnea_pkg::t_cfg                     i_wr,
    output logic [$clog2(MAX_SEATS+1)-1:0]     o_ring_n,
    output logic                               o_enable
);
    localparam int CW = $clog2(MAX_SEATS + 1);

    logic [rnea_pkg::SEAT_COUNT_W-1:0] r_seat_count;
    logic                              r_enable;

    // Register writes; indexes outside the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seat_count <= rnea_pkg::SEAT_COUNT_RESET;
            r_enable     <= rnea_pkg::ENABLE_RESET;
        end else if (i_wr_en) begin
            case (i_wr.index)
                rnea_pkg::CFG_SEAT_COUNT: r_seat_count <= i_wr.data;
                rnea_pkg::CFG_ENABLE:     r_enable     <= i_wr.data[0];
                default: ;
            endcase
        end
    end

    // Clamp the seat count into the supported ring sizes.
    always_comb begin
        if (int'(r_seat_count) < rnea_pkg::MIN_SEATS) begin
            o_ring_n = CW'(rnea_pkg::MIN_SEATS);
        end else if (int'(r_seat_count) > MAX_SEATS) begin
            o_ring_n = CW'(MAX_SEATS);
        end else begin
            o_ring_n = CW'(r_seat_count);
        end
    end

    assign o_enable = r_enable;

endmodule

@@ rtl/rnea_core.sv @@
// Seat states, meal counters and the single-pass grant logic for one event.
module rnea_core #(
    parameter int MAX_SEATS  = rnea_pkg::DEF_MAX_SEATS,
    parameter int MEAL_WIDTH = rnea_pkg::DEF_MEAL_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  rnea_pkg::t_req                 i_evt,
    input  logic [$clog2(MAX_SEATS+1)-1:0] i_ring_n,
    input  logic                           i_enable,
    output rnea_pkg::t_rsp                 o_rsp
);
    localparam int CW = $clog2(MAX_SEATS + 1);
    localparam int MW = rnea_pkg::MASK_W;
    localparam int OW = rnea_pkg::MEALS_OUT_W;

    // Per-seat state: eating and hungry bits; neither set means thinking.
    logic [MAX_SEATS-1:0]  r_eat, n_eat;
    logic [MAX_SEATS-1:0]  r_hungry, n_hungry;
    logic [MEAL_WIDTH-1:0] r_meal [MAX_SEATS];
    logic [MEAL_WIDTH-1:0] n_meal [MAX_SEATS];

    logic [MAX_SEATS-1:0]  tgt, lft, rgt, in_use;
    logic [MAX_SEATS-1:0]  e1, h1, nb1, e2, h2, nb2;
    logic [MAX_SEATS-1:0]  g_self, g_left, g_right, grants;
    logic                  bad, apply, g_l;
    logic [MEAL_WIDTH-1:0] sel_meal;
    logic [MEAL_WIDTH+OW-1:0] meal_pad;

    // Bit i is set when either ring neighbor of seat i eats.
    function automatic logic [MAX_SEATS-1:0] nbr_eat(
        input logic [MAX_SEATS-1:0] e,
        input logic [CW-1:0]        n
    );
        logic [MAX_SEATS-1:0] r;
        logic                 last;
        logic                 lo;
        logic                 hi;
        last = 1'b0;
        for (int i = 0; i < MAX_SEATS; i++) begin
            if (i == int'(n) - 1) begin
                last = e[i];
            end
        end
        for (int i = 0; i < MAX_SEATS; i++) begin
            lo   = (i == 0) ? last : e[(i + MAX_SEATS - 1) % MAX_SEATS];
            hi   = (i == int'(n) - 1) ? e[0] : e[(i + 1) % MAX_SEATS];
            r[i] = lo | hi;
        end
        return r;
    endfunction

    // Low byte of a seat vector, zero-padded for small rings.
    function automatic logic [MW-1:0] low_byte(input logic [MAX_SEATS-1:0] v);
        logic [MAX_SEATS+MW-1:0] p;
        p = {{MW{1'b0}}, v};
        return p[MW-1:0];
    endfunction

    // Decode the event seat and its two ring neighbors into one-hot vectors.
    always_comb begin
        bad = (int'(i_evt.seat) >= int'(i_ring_n));
        for (int i = 0; i < MAX_SEATS; i++) begin
            tgt[i]    = (i == int'(i_evt.seat));
            lft[i]    = (i_evt.seat == '0) ? (i == int'(i_ring_n) - 1)
                                           : (i == int'(i_evt.seat) - 1);
            rgt[i]    = (int'(i_evt.seat) == int'(i_ring_n) - 1) ? (i == 0)
                                           : (i == int'(i_evt.seat) + 1);
            in_use[i] = (i < int'(i_ring_n));
        end
    end

    // Grant logic: acquire tests the seat itself; release tests left then right.
    always_comb begin
        apply = !bad && ((i_evt.mode == rnea_pkg::MODE_RELEASE) || i_enable);
        e1    = r_eat & ~tgt;
        h1    = (i_evt.mode == rnea_pkg::MODE_ACQUIRE) ? (r_hungry | tgt)
                                                        : (r_hungry & ~tgt);
        nb1   = nbr_eat(e1, i_ring_n);

        g_self = (i_enable && (i_evt.mode == rnea_pkg::MODE_ACQUIRE))
                 ? (tgt & h1 & ~nb1) : '0;

        g_l    = i_enable && (i_evt.mode == rnea_pkg::MODE_RELEASE)
                 && (|(lft & h1 & ~nb1));
        g_left = g_l ? lft : '0;
        e2     = e1 | g_left;
        h2     = h1 & ~g_left;
        nb2    = nbr_eat(e2, i_ring_n);

        g_right = (i_enable && (i_evt.mode == rnea_pkg::MODE_RELEASE))
                  ? (rgt & h2 & ~nb2) : '0;

        grants = apply ? (g_self | g_left | g_right) : '0;
        if (apply) begin
            n_eat    = e1 | grants;
            n_hungry = h1 & ~grants;
        end else begin
            n_eat    = r_eat;
            n_hungry = r_hungry;
        end
    end

    // Saturating meal counters and the event seat's updated count.
    always_comb begin
        sel_meal = '0;
        for (int i = 0; i < MAX_SEATS; i++) begin
            n_meal[i] = r_meal[i];
            if (grants[i] && (r_meal[i] != {MEAL_WIDTH{1'b1}})) begin
                n_meal[i] = r_meal[i] + MEAL_WIDTH'(1);
            end
            if (i == int'(i_evt.seat)) begin
                sel_meal = n_meal[i];
            end
        end
        meal_pad = {{OW{1'b0}}, (bad ? {MEAL_WIDTH{1'b0}} : sel_meal)};
    end

    // Result of the event, taken by the output register.
    always_comb begin
        o_rsp.grant_mask  = low_byte(grants);
        o_rsp.eating_mask = low_byte(n_eat & in_use);
        o_rsp.hungry_mask = low_byte(n_hungry & in_use);
        o_rsp.seat_meals  = meal_pad[OW-1:0];
        o_rsp.bad_seat    = bad;
    end

    // State update when the event leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eat    <= '0;
            r_hungry <= '0;
            for (int i = 0; i < MAX_SEATS; i++) begin
                r_meal[i] <= '0;
            end
        end else if (i_fire) begin
            r_eat    <= n_eat;
            r_hungry <= n_hungry;
            for (int i = 0; i < MAX_SEATS; i++) begin
                r_meal[i] <= n_meal[i];
            end
        end
    end

endmodule

@@ rtl/ring_neighbor_exclusion_arbiter.sv @@
// Top level of the ring neighbor exclusion arbiter: input and result registers.
//
//   channel  | modport | payload                                   | accepted when
//   i_req    | sink    | mode, seat                                | valid && ready
//   o_rsp    | source  | grant_mask, eating_mask, hungry_mask,     | valid && ready
//            |         | seat_meals, bad_seat                      |
//   i_cfg    | sink    | index (0 seat_count, 1 enable), data      | valid && ready
//
// One request per cycle sustained while o_rsp does not stall. An accepted request
// is held in the input register, and the grant logic and state update then write
// its result into the result register. The result register frees the input side,
// so a new request is taken while a result waits. A stalled result holds the input
// register, and the request port then drops ready. Reset (synchronous, active low)
// makes every seat think, clears the meal counters and sets seat_count to 8 and
// enable to 1.
module ring_neighbor_exclusion_arbiter #(
    parameter int MAX_SEATS  = rnea_pkg::DEF_MAX_SEATS,
    parameter int MEAL_WIDTH = rnea_pkg::DEF_MEAL_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rnea_req_if.sink          i_req,
    rnea_rsp_if.source        o_rsp,
    rnea_cfg_if.sink          i_cfg
);
    localparam int CW = $clog2(MAX_SEATS + 1);

    logic           r_in_valid;
    rnea_pkg::t_req r_in;
    logic           r_out_valid;
    rnea_pkg::t_rsp r_out;
    logic           advance;
    logic [CW-1:0]  ring_n;
    logic           enable;
    rnea_pkg::t_rsp core_rsp;

    // Configuration registers are always ready.
    assign i_cfg.ready = 1'b1;

    rnea_cfg_regs #(
        .MAX_SEATS (MAX_SEATS)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (i_cfg.valid),
        .i_wr     (i_cfg.payload),
        .o_ring_n (ring_n),
        .o_enable (enable)
    );

    // The held request is processed when the result register can take it.
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    rnea_core #(
        .MAX_SEATS  (MAX_SEATS),
        .MEAL_WIDTH (MEAL_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_evt    (r_in),
        .i_ring_n (ring_n),
        .i_enable (enable),
        .o_rsp    (core_rsp)
    );

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.payload;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_rsp;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule
